// ===== sv/mss_pkg.sv =====
// Shared widths and register codes for the multi-axis speed sync unit.
// No dependencies; imported by every module of the block.
package mss_pkg;

  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned STEP_W   = 21;
  localparam int unsigned LIM_W    = 16;
  localparam int unsigned PROD_W   = LIM_W + STEP_W;

  localparam int unsigned IN_TDATA_W  = ((NUM_AXES * STEP_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 * NUM_AXES * LIM_W + 7) / 8) * 8;

  localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 16'd500;
  localparam logic [LIM_W-1:0] ACCEL_LIMIT_RST = 16'd2000;

  typedef enum logic {
    REG_SPEED_LIMIT = 1'b0,
    REG_ACCEL_LIMIT = 1'b1
  } reg_idx_e;

endpackage

// ===== sv/mss_front.sv =====
// Front end: step magnitudes, largest magnitude and limit products, two stages.
// Depends on mss_pkg.
module mss_front import mss_pkg::*; #(
  parameter int unsigned AXES = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [STEP_W-1:0] steps_i [AXES],
  input  logic [LIM_W-1:0]         speed_limit_i,
  input  logic [LIM_W-1:0]         accel_limit_i,
  output logic                     valid_o,
  output logic [PROD_W-1:0]        prod_o [2*AXES],
  output logic [STEP_W-1:0]        divisor_o
);

  logic              mag_v_q;
  logic [STEP_W-1:0] mag_d [AXES];
  logic [STEP_W-1:0] mag_q [AXES];
  logic              prod_v_q;
  logic [PROD_W-1:0] prod_d [2*AXES];
  logic [PROD_W-1:0] prod_q [2*AXES];
  logic [STEP_W-1:0] divisor_d;
  logic [STEP_W-1:0] divisor_q;
  logic [STEP_W-1:0] largest;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (steps_i[i][STEP_W-1]) begin
        mag_d[i] = ~steps_i[i] + STEP_W'(1);
      end else begin
        mag_d[i] = steps_i[i];
      end
    end
  end

  always_comb begin
    largest = '0;
    for (int i = 0; i < AXES; i++) begin
      if (mag_q[i] > largest) begin
        largest = mag_q[i];
      end
    end
    // all axes idle: a divisor of one gives zero quotients
    divisor_d = (largest == '0) ? STEP_W'(1) : largest;
    for (int i = 0; i < AXES; i++) begin
      prod_d[i]        = PROD_W'(speed_limit_i) * PROD_W'(mag_q[i]);
      prod_d[AXES + i] = PROD_W'(accel_limit_i) * PROD_W'(mag_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else if (en_i) begin
      mag_v_q  <= valid_i;
      prod_v_q <= mag_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q     <= mag_d;
      prod_q    <= prod_d;
      divisor_q <= divisor_d;
    end
  end

  assign valid_o   = prod_v_q;
  assign prod_o    = prod_q;
  assign divisor_o = divisor_q;

endmodule

// ===== sv/mss_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor per item.
// Depends on mss_pkg.
module mss_divider import mss_pkg::*; #(
  parameter int unsigned LANES = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PROD_W-1:0] dividend_i [LANES],
  input  logic [STEP_W-1:0] divisor_i,
  output logic              valid_o,
  output logic [LIM_W-1:0]  quot_o [LANES]
);

  logic              v_q   [LIM_W];
  logic [STEP_W-1:0] dvs_q [LIM_W];
  logic [STEP_W-1:0] rem_q [LIM_W][LANES];
  logic [LIM_W-1:0]  sh_q  [LIM_W][LANES];
  logic [STEP_W-1:0] rem_d [LIM_W][LANES];
  logic [LIM_W-1:0]  sh_d  [LIM_W][LANES];

  function automatic logic [STEP_W+LIM_W-1:0] div_step(
    input logic [STEP_W-1:0] rem,
    input logic [LIM_W-1:0]  sh,
    input logic [STEP_W-1:0] dvs
  );
    logic [STEP_W:0] trial;
    logic [STEP_W:0] diff;
    trial = {rem, sh[LIM_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {diff[STEP_W-1:0], sh[LIM_W-2:0], 1'b1};
    end
    return {trial[STEP_W-1:0], sh[LIM_W-2:0], 1'b0};
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      {rem_d[0][l], sh_d[0][l]} = div_step(dividend_i[l][PROD_W-1:LIM_W],
                                           dividend_i[l][LIM_W-1:0], divisor_i);
      for (int k = 1; k < LIM_W; k++) begin
        {rem_d[k][l], sh_d[k][l]} = div_step(rem_q[k-1][l], sh_q[k-1][l], dvs_q[k-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LIM_W; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < LIM_W; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q[0] <= divisor_i;
      for (int k = 1; k < LIM_W; k++) begin
        dvs_q[k] <= dvs_q[k-1];
      end
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign valid_o = v_q[LIM_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = sh_q[LIM_W-1][l];
    end
  end

endmodule

// ===== sv/mss_skid.sv =====
// Output register with a skid slot; stalls the pipeline only while the slot is full.
// Depends on mss_pkg.
module mss_skid import mss_pkg::*; #(
  parameter int unsigned W = OUT_TDATA_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         en_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         ready_i
);

  logic         out_v_q;
  logic         out_v_d;
  logic [W-1:0] out_q;
  logic [W-1:0] out_d;
  logic         skid_v_q;
  logic         skid_v_d;
  logic [W-1:0] skid_q;
  logic         arrive;

  assign en_o   = !skid_v_q;
  assign arrive = valid_i && !skid_v_q;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    if (out_v_q && !ready_i) begin
      // hold the output, park a new item in the skid slot
      if (arrive) begin
        skid_v_d = 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_d  = 1'b1;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end else begin
      out_v_d = arrive;
      out_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (arrive && out_v_q && !ready_i) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

// ===== sv/multi_axis_speed_sync_unit.sv =====
// Multi-axis speed sync unit: top level with configuration registers and stream ports.
// Depends on mss_pkg, mss_front, mss_divider and mss_skid.
//
// One move command enters on the s_axis channel with a signed step count per axis.
// One result leaves on the m_axis channel: per axis, a peak speed of
// floor(speed_limit*|steps|/largest) and an acceleration of
// floor(accel_limit*|steps|/largest); all zero when no axis moves.
// The limits are written through the APB port (speed_limit at 0x0, accel_limit
// at 0x4); write them only while no item is in flight: the block does not enforce it.
// Each item passes two front stages (magnitude, then maximum and products),
// sixteen divider stages that each resolve one quotient bit, and the output register.
// Throughput: one item per cycle, set by the fully pipelined divider, unless stalled.
// Reset clears every valid bit and loads the limits with 500 and 2000.
// When the receiver stalls, the item already at the output register holds,
// the next one moves into a skid slot, and only then does s_axis_tready fall;
// the whole pipeline then holds until the output is taken.
module multi_axis_speed_sync_unit import mss_pkg::*; #(
  parameter int unsigned AXES = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // steps_axis1..steps_axis6, 21 bits each, from bit 0 up; top bits zero
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // speed_axis1..speed_axis6, accel_axis1..accel_axis6, 16 bits each, from bit 0 up
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [LIM_W-1:0]         speed_limit_q;
  logic [LIM_W-1:0]         accel_limit_q;
  logic                     wr_en;
  reg_idx_e                 wr_idx;
  logic                     en;
  logic signed [STEP_W-1:0] steps [AXES];
  logic                     front_v;
  logic [PROD_W-1:0]        prod [2*AXES];
  logic [STEP_W-1:0]        divisor;
  logic                     div_v;
  logic [LIM_W-1:0]         quot [2*AXES];
  logic [OUT_TDATA_W-1:0]   res_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RST;
      accel_limit_q <= ACCEL_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_idx)
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[LIM_W-1:0];
        REG_ACCEL_LIMIT: accel_limit_q <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_SPEED_LIMIT: prdata = {{(32-LIM_W){1'b0}}, speed_limit_q};
      REG_ACCEL_LIMIT: prdata = {{(32-LIM_W){1'b0}}, accel_limit_q};
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      steps[i] = s_axis_tdata[i*STEP_W +: STEP_W];
    end
  end

  assign s_axis_tready = en;

  mss_front #(
    .AXES (AXES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .steps_i       (steps),
    .speed_limit_i (speed_limit_q),
    .accel_limit_i (accel_limit_q),
    .valid_o       (front_v),
    .prod_o        (prod),
    .divisor_o     (divisor)
  );

  mss_divider #(
    .LANES (2 * AXES)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (front_v),
    .dividend_i (prod),
    .divisor_i  (divisor),
    .valid_o    (div_v),
    .quot_o     (quot)
  );

  always_comb begin
    res_data = '0;
    for (int i = 0; i < AXES; i++) begin
      res_data[i*LIM_W +: LIM_W]              = quot[i];
      res_data[(NUM_AXES + i)*LIM_W +: LIM_W] = quot[AXES + i];
    end
  end

  mss_skid #(
    .W (OUT_TDATA_W)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .data_i  (res_data),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .ready_i (m_axis_tready)
  );

endmodule

// ===== tb/mss_rate_checker.sv =====
// Checker for the multi-axis speed sync unit: tracks the limit registers from APB writes,
// predicts per-axis speed and acceleration for every accepted move and compares results.
// Depends on mss_pkg.
module mss_rate_checker import mss_pkg::*; #(
  parameter int unsigned AXES = NUM_AXES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [2:0]             paddr_i,
  input  logic [31:0]            pwdata_i,
  input  logic                   pready_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     fail_cnt_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [NUM_AXES-1:0][LIM_W-1:0] accel;
    logic [NUM_AXES-1:0][LIM_W-1:0] speed;
  } axis_rates_t;

  logic [LIM_W-1:0] speed_lim;
  logic [LIM_W-1:0] accel_lim;
  axis_rates_t      rates_q [$];
  int               fail_total;

  function automatic axis_rates_t scale_move(logic [IN_TDATA_W-1:0] cmd);
    logic [NUM_AXES-1:0][STEP_W-1:0] mag;
    logic [STEP_W-1:0]               step;
    logic [STEP_W-1:0]               largest;
    logic [PROD_W-1:0]               speed_prod;
    logic [PROD_W-1:0]               accel_prod;
    axis_rates_t                     r;
    largest = '0;
    r       = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      step = cmd[k*STEP_W +: STEP_W];
      if (k >= AXES) begin
        mag[k] = '0;
      end else if (step[STEP_W-1]) begin
        mag[k] = ~step + 1'b1;
      end else begin
        mag[k] = step;
      end
      if (mag[k] > largest) largest = mag[k];
    end
    if (largest != '0) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        speed_prod = PROD_W'(speed_lim) * PROD_W'(mag[k]);
        accel_prod = PROD_W'(accel_lim) * PROD_W'(mag[k]);
        speed_prod = speed_prod / PROD_W'(largest);
        accel_prod = accel_prod / PROD_W'(largest);
        r.speed[k] = speed_prod[LIM_W-1:0];
        r.accel[k] = accel_prod[LIM_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    axis_rates_t want;
    axis_rates_t got;
    if (!rst_ni) begin
      speed_lim  = SPEED_LIMIT_RST;
      accel_lim  = ACCEL_LIMIT_RST;
      rates_q.delete();
      fail_total = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_SPEED_LIMIT: speed_lim = pwdata_i[LIM_W-1:0];
          REG_ACCEL_LIMIT: accel_lim = pwdata_i[LIM_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[2*NUM_AXES*LIM_W-1:0];
        if (rates_q.size() == 0) begin
          $error("result item with no move command pending");
          fail_total++;
        end else begin
          want = rates_q.pop_front();
          for (int k = 0; k < NUM_AXES; k++) begin
            if (got.speed[k] !== want.speed[k]) begin
              $error("speed_axis%0d: expected %0d, got %0d", k + 1, want.speed[k],
                     got.speed[k]);
              fail_total++;
            end
            if (got.accel[k] !== want.accel[k]) begin
              $error("accel_axis%0d: expected %0d, got %0d", k + 1, want.accel[k],
                     got.accel[k]);
              fail_total++;
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) rates_q.push_back(scale_move(s_tdata_i));
      fail_cnt_o <= fail_total;
      pending_o  <= rates_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the multi-axis speed sync unit testbench: clock, reset, APB limit writes,
// move stimulus with random idling on both streams, and the verdict.
// Depends on mss_pkg, multi_axis_speed_sync_unit and mss_rate_checker.
module testbench import mss_pkg::*;;

  localparam int unsigned RAND_ITEMS   = 650;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int          fail_cnt;
  int          pending;
  int unsigned cycle_cnt = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  multi_axis_speed_sync_unit dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  mss_rate_checker rate_chk (
    .clk_i,
    .rst_ni,
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .pready_i   (pready),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("multi_axis_speed_sync_unit: mismatch");
      $finish;
    end
  end

  // Result side: unless in a steady phase, stall a random number of cycles before taking each item.
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_move(input logic [NUM_AXES-1:0][STEP_W-1:0] cmd);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_W'(cmd);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [LIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [STEP_W-1:0] rand_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = 21'h0FFFFF;
      2:       s = 21'h100000;
      3, 4:    s = STEP_W'($urandom_range(0, 32)) - 21'd16;
      default: s = STEP_W'($urandom());
    endcase
    return s;
  endfunction

  initial begin
    logic [NUM_AXES-1:0][STEP_W-1:0] cmd;
    logic [LIM_W-1:0]                spd_cfg [PHASES];
    logic [LIM_W-1:0]                acc_cfg [PHASES];
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    spd_cfg = '{SPEED_LIMIT_RST, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1,
                LIM_W'($urandom())};
    acc_cfg = '{ACCEL_LIMIT_RST, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1,
                LIM_W'($urandom())};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cmd = '0;
    send_move(cmd);
    cmd[0] = 21'h0FFFFF;
    send_move(cmd);
    cmd[0] = 21'h100000;
    send_move(cmd);
    cmd = {NUM_AXES{21'h100000}};
    send_move(cmd);
    cmd = {NUM_AXES{21'h0FFFFF}};
    send_move(cmd);
    cmd = {21'(524288), 21'(0), 21'(-1), 21'(1), 21'(1048575), 21'(-1048576)};
    send_move(cmd);
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int j = 0; j < NUM_AXES; j++) cmd[j] = (j == k) ? 21'(-1000) : 21'(37 * (j + 1));
      send_move(cmd);
    end
    cmd = '0;
    cmd[0] = 21'd1;
    send_move(cmd);
    cmd = {21'(-1), 21'(1), 21'(-1), 21'(1), 21'(-1), 21'(1)};
    send_move(cmd);
    cmd = {21'(-2), 21'(-1), 21'(0), 21'(1), 21'(2), 21'(3)};
    send_move(cmd);
    cmd = '0;
    cmd[5] = 21'(-7);
    send_move(cmd);
    cmd = {21'(3), 21'(2), 21'(1), 21'(-666666), 21'(333333), 21'(999999)};
    send_move(cmd);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        apb_write(REG_SPEED_LIMIT, spd_cfg[ph]);
        apb_write(REG_ACCEL_LIMIT, acc_cfg[ph]);
      end
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) begin
          tx_steady = (ph == 0 && n == 0) || ($urandom_range(0, 3) == 0);
          rx_steady = (ph == 0 && n == 0) || ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 24) == 0) begin
          cmd = '0;
        end else begin
          for (int k = 0; k < NUM_AXES; k++) cmd[k] = rand_step();
        end
        send_move(cmd);
      end
    end
    settle();

    if (fail_cnt == 0 && pending == 0) begin
      $display("multi_axis_speed_sync_unit: match");
    end else begin
      $display("multi_axis_speed_sync_unit: mismatch");
    end
    $finish;
  end

endmodule
